/* design/cps_pkg.sv */
// Shared types, constants and state codes for the curve peak score block.
`default_nettype none

package cps_pkg;

	localparam int MAX_SAMPLES_DEF = 64;
	localparam int SAMPLE_W = 32;
	localparam int REG_W = 6;
	localparam int CFG_IDX_W = 1;
	localparam int SCORE_W = 24;

	// Quotient bits kept by the divider: 8 integer guard bits, 16 fraction bits
	// and one rounding bit.
	localparam int GUARD_W = 8;
	localparam int QUO_W = 25;
	localparam int STEP_W = $clog2(QUO_W);

	localparam logic signed [SCORE_W-1:0] SCORE_MAX = 24'sh7FFFFF;
	localparam logic signed [SCORE_W-1:0] SCORE_MIN = 24'sh800000;
	localparam logic [QUO_W-1:0] SAT_POS_MAG = 25'd8388607;
	localparam logic [QUO_W-1:0] SAT_NEG_MAG = 25'd8388608;

	localparam logic [CFG_IDX_W-1:0] REG_REFERENCE_INDEX = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LOOKBACK_LENGTH = 1'd1;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] sample;
		logic                       is_last;
	} in_word_t;

	typedef struct packed {
		logic signed [SCORE_W-1:0] score;
		logic                      flat_error;
	} out_word_t;

	typedef enum logic [3:0] {
		ST_LOAD,
		ST_SETUP,
		ST_PEAK,
		ST_COUNT,
		ST_MUL_MIN,
		ST_MUL_SPAN,
		ST_MUL_DEN,
		ST_MUL_NUM,
		ST_ABS,
		ST_DIV_CHK,
		ST_DIV,
		ST_FINISH
	} state_t;

endpackage

`default_nettype wire

/* design/cps_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module cps_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

/* design/curve_peak_score.sv */
// Curve peak score: sample store, scan sequencer, shared multiplier and serial divider.
//
// Samples stream in one word per cycle and go to the sample RAM while the running
// minimum, maximum and sum are updated; samples beyond MAX_SAMPLES are dropped. The
// word with is_last set closes the curve and the block stops taking input until the
// score is computed: a setup state, a RAM scan of the peak window, a RAM scan of the
// whole curve, four passes through the one shared multiplier plus a magnitude step,
// and a restoring divider with a check state and 25 quotient bits at one bit per
// cycle, then a finish state that rounds and saturates. The divider is skipped when
// the check already sees saturation; a flat curve goes from setup straight to finish.
// The result sits in an output register, so the next curve may load while it waits.
`default_nettype none

module curve_peak_score #(
	parameter int MAX_SAMPLES = cps_pkg::MAX_SAMPLES_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           in_valid,
	output logic                                in_ready,
	input  wire cps_pkg::in_word_t              in_word,
	output logic                                out_valid,
	input  wire logic                           out_ready,
	output cps_pkg::out_word_t                  out_word,
	input  wire logic                           cfg_write,
	input  wire logic [cps_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [cps_pkg::REG_W-1:0]      cfg_data
);

	localparam int AW = $clog2(MAX_SAMPLES);
	localparam int CW = $clog2(MAX_SAMPLES + 1);
	localparam int XW = (CW > cps_pkg::REG_W) ? CW : cps_pkg::REG_W;
	localparam int SW = cps_pkg::SAMPLE_W + AW;
	localparam int IW = SW + 1;
	localparam int PW = CW + 1 + IW;
	localparam int MW = cps_pkg::SAMPLE_W + 2 * AW;
	localparam int RW = MW + cps_pkg::GUARD_W + 1;
	localparam int QW = cps_pkg::QUO_W;

	cps_pkg::state_t state_q, state_d;

	// Configuration registers.
	logic [cps_pkg::REG_W-1:0] reference_index_q;
	logic [cps_pkg::REG_W-1:0] lookback_length_q;

	// Curve statistics.
	logic [CW-1:0]                      count_q;
	logic signed [cps_pkg::SAMPLE_W-1:0] min_q;
	logic signed [cps_pkg::SAMPLE_W-1:0] max_q;
	logic signed [SW-1:0]               sum_q;

	// Scan sequencer.
	logic [AW-1:0] ptr_q;
	logic [AW-1:0] end_q;
	logic          issue_q;
	logic          vld_s1;
	logic          last_s1;

	// Datapath registers.
	logic signed [cps_pkg::SAMPLE_W-1:0] peak_q;
	logic [CW-1:0]                      cnt_q;
	logic signed [PW-1:0]               mul_q;
	logic signed [IW-1:0]               d_q;
	logic signed [IW-1:0]               inner_q;
	logic [MW-1:0]                      den_q;
	logic [RW-1:0]                      rem_q;
	logic [QW-1:0]                      quo_q;
	logic [cps_pkg::STEP_W-1:0]         step_q;
	logic                               neg_q;
	logic                               sat_q;
	logic                               flat_q;

	logic               out_valid_q;
	cps_pkg::out_word_t out_word_q;

	// Combinational signals.
	logic                               in_fire;
	logic                               store_ok;
	logic                               fin_fire;
	logic                               scan_done;
	logic                               is_flat;
	logic [XW-1:0]                      ref_x;
	logic [XW-1:0]                      cnt_x;
	logic [XW-1:0]                      lb_x;
	logic [XW-1:0]                      ref_c;
	logic [XW-1:0]                      start_c;
	logic [CW-1:0]                      cnt_m1;
	logic [cps_pkg::SAMPLE_W-1:0]       rdata;
	logic signed [cps_pkg::SAMPLE_W-1:0] rd_sample;
	logic [32:0]                        span_w;
	logic [CW-1:0]                      mul_a;
	logic signed [IW-1:0]               mul_b;
	logic signed [MW:0]                 numer_w;
	logic [MW:0]                        mag_w;
	logic [RW-2:0]                      dv_w;
	logic [RW-1:0]                      r2_w;
	logic                               r2_ge;
	logic [QW:0]                        rnd_sum;
	logic [QW-1:0]                      mag_r;
	logic signed [cps_pkg::SCORE_W-1:0] score_w;

	assign in_fire  = in_valid && in_ready;
	assign store_ok = count_q < CW'(MAX_SAMPLES);
	assign fin_fire = (state_q == cps_pkg::ST_FINISH) && (!out_valid_q || out_ready);
	assign scan_done = vld_s1 && last_s1;
	assign is_flat  = (count_q == '0) || (max_q == min_q);

	// Window bounds: the reference is clamped into the curve, the start at index 0.
	assign ref_x   = XW'(reference_index_q);
	assign cnt_x   = XW'(count_q);
	assign lb_x    = XW'(lookback_length_q);
	assign ref_c   = (ref_x >= cnt_x) ? (cnt_x - 1'b1) : ref_x;
	assign start_c = (lb_x > ref_c) ? '0 : (ref_c - lb_x);
	assign cnt_m1  = count_q - 1'b1;

	assign rd_sample = $signed(rdata);
	assign span_w    = {peak_q[cps_pkg::SAMPLE_W-1], peak_q} - {min_q[cps_pkg::SAMPLE_W-1], min_q};

	assign numer_w = $signed(mul_q[MW:0]);
	assign mag_w   = numer_w[MW] ? (~numer_w + 1'b1) : numer_w;

	// The divisor is shifted up by the guard bits so that the quotient fits QW bits.
	assign dv_w  = {den_q, {cps_pkg::GUARD_W{1'b0}}};
	assign r2_w  = {rem_q[RW-2:0], 1'b0};
	assign r2_ge = r2_w >= {1'b0, dv_w};

	assign rnd_sum = {1'b0, quo_q} + 1'b1;
	assign mag_r   = rnd_sum[QW:1];

	always_comb begin
		if (flat_q) begin
			score_w = '0;
		end else if (!neg_q) begin
			score_w = (sat_q || (mag_r > cps_pkg::SAT_POS_MAG)) ? cps_pkg::SCORE_MAX
				: $signed(mag_r[cps_pkg::SCORE_W-1:0]);
		end else begin
			score_w = (sat_q || (mag_r > cps_pkg::SAT_NEG_MAG)) ? cps_pkg::SCORE_MIN
				: $signed(~mag_r[cps_pkg::SCORE_W-1:0] + 1'b1);
		end
	end

	// Shared multiplier operand select.
	always_comb begin
		mul_a = count_q;
		mul_b = '0;
		case (state_q)
			cps_pkg::ST_MUL_MIN:  mul_b = IW'(min_q);
			cps_pkg::ST_MUL_SPAN: mul_b = $signed({{(IW-33){1'b0}}, span_w});
			cps_pkg::ST_MUL_DEN:  mul_b = d_q;
			cps_pkg::ST_MUL_NUM: begin
				mul_a = cnt_q;
				mul_b = inner_q;
			end
			default: mul_b = '0;
		endcase
	end

	cps_ram #(
		.WIDTH(cps_pkg::SAMPLE_W),
		.DEPTH(MAX_SAMPLES)
	) u_store (
		.clk  (clk),
		.we   (in_fire && store_ok),
		.waddr(count_q[AW-1:0]),
		.wdata(in_word.sample),
		.raddr(ptr_q),
		.rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cps_pkg::ST_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		case (state_q)
			cps_pkg::ST_LOAD: begin
				in_ready = 1'b1;
				if (in_valid && in_word.is_last) begin
					state_d = cps_pkg::ST_SETUP;
				end
			end
			cps_pkg::ST_SETUP:    state_d = is_flat ? cps_pkg::ST_FINISH : cps_pkg::ST_PEAK;
			cps_pkg::ST_PEAK:     state_d = scan_done ? cps_pkg::ST_COUNT : cps_pkg::ST_PEAK;
			cps_pkg::ST_COUNT:    state_d = scan_done ? cps_pkg::ST_MUL_MIN : cps_pkg::ST_COUNT;
			cps_pkg::ST_MUL_MIN:  state_d = cps_pkg::ST_MUL_SPAN;
			cps_pkg::ST_MUL_SPAN: state_d = cps_pkg::ST_MUL_DEN;
			cps_pkg::ST_MUL_DEN:  state_d = cps_pkg::ST_MUL_NUM;
			cps_pkg::ST_MUL_NUM:  state_d = cps_pkg::ST_ABS;
			cps_pkg::ST_ABS:      state_d = cps_pkg::ST_DIV_CHK;
			cps_pkg::ST_DIV_CHK: begin
				state_d = (rem_q >= {1'b0, dv_w}) ? cps_pkg::ST_FINISH : cps_pkg::ST_DIV;
			end
			cps_pkg::ST_DIV: begin
				if (step_q == cps_pkg::STEP_W'(QW - 1)) begin
					state_d = cps_pkg::ST_FINISH;
				end
			end
			cps_pkg::ST_FINISH: begin
				if (!out_valid_q || out_ready) begin
					state_d = cps_pkg::ST_LOAD;
				end
			end
			default: state_d = cps_pkg::ST_LOAD;
		endcase
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reference_index_q <= '0;
			lookback_length_q <= '0;
		end else if (cfg_write) begin
			case (cfg_index)
				cps_pkg::REG_REFERENCE_INDEX: reference_index_q <= cfg_data;
				cps_pkg::REG_LOOKBACK_LENGTH: lookback_length_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Running statistics; a new curve starts once the result is handed over.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			min_q   <= '0;
			max_q   <= '0;
			sum_q   <= '0;
		end else if (fin_fire) begin
			count_q <= '0;
			min_q   <= '0;
			max_q   <= '0;
			sum_q   <= '0;
		end else if (in_fire && store_ok) begin
			if (count_q == '0) begin
				min_q <= in_word.sample;
				max_q <= in_word.sample;
			end else begin
				if (in_word.sample < min_q) begin
					min_q <= in_word.sample;
				end
				if (in_word.sample > max_q) begin
					max_q <= in_word.sample;
				end
			end
			sum_q   <= sum_q + SW'(in_word.sample);
			count_q <= count_q + 1'b1;
		end
	end

	// Scan sequencer: one RAM address per cycle, with the read data back in the next cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q   <= '0;
			end_q   <= '0;
			issue_q <= 1'b0;
			vld_s1  <= 1'b0;
			last_s1 <= 1'b0;
			step_q  <= '0;
		end else begin
			if (state_q == cps_pkg::ST_SETUP) begin
				ptr_q   <= start_c[AW-1:0];
				end_q   <= ref_c[AW-1:0];
				issue_q <= !is_flat;
				vld_s1  <= 1'b0;
			end else if (state_q == cps_pkg::ST_PEAK && scan_done) begin
				ptr_q   <= '0;
				end_q   <= cnt_m1[AW-1:0];
				issue_q <= 1'b1;
				vld_s1  <= 1'b0;
			end else if (issue_q) begin
				vld_s1  <= 1'b1;
				last_s1 <= (ptr_q == end_q);
				ptr_q   <= ptr_q + 1'b1;
				if (ptr_q == end_q) begin
					issue_q <= 1'b0;
				end
			end else begin
				vld_s1 <= 1'b0;
			end
			if (state_q == cps_pkg::ST_DIV_CHK) begin
				step_q <= '0;
			end else if (state_q == cps_pkg::ST_DIV) begin
				step_q <= step_q + 1'b1;
			end
		end
	end

	// Arithmetic datapath.
	always_ff @(posedge clk) begin
		mul_q <= $signed({1'b0, mul_a}) * mul_b;
		case (state_q)
			cps_pkg::ST_SETUP: begin
				flat_q <= is_flat;
				neg_q  <= 1'b0;
				sat_q  <= 1'b0;
				peak_q <= {1'b1, {(cps_pkg::SAMPLE_W-1){1'b0}}};
				cnt_q  <= '0;
			end
			cps_pkg::ST_PEAK: begin
				if (vld_s1 && (rd_sample > peak_q)) begin
					peak_q <= rd_sample;
				end
			end
			cps_pkg::ST_COUNT: begin
				if (vld_s1 && (rd_sample <= peak_q)) begin
					cnt_q <= cnt_q + 1'b1;
				end
			end
			cps_pkg::ST_MUL_SPAN: d_q <= {sum_q[SW-1], sum_q} - mul_q[IW-1:0];
			cps_pkg::ST_MUL_DEN:  inner_q <= mul_q[IW-1:0] - d_q;
			cps_pkg::ST_MUL_NUM:  den_q <= mul_q[MW-1:0];
			cps_pkg::ST_ABS: begin
				neg_q <= numer_w[MW];
				rem_q <= {{(RW-MW-1){1'b0}}, mag_w};
			end
			cps_pkg::ST_DIV_CHK: begin
				sat_q <= rem_q >= {1'b0, dv_w};
				quo_q <= '0;
			end
			cps_pkg::ST_DIV: begin
				rem_q <= r2_ge ? (r2_w - {1'b0, dv_w}) : r2_w;
				quo_q <= {quo_q[QW-2:0], r2_ge};
			end
			default: ;
		endcase
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fin_fire) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fin_fire) begin
			out_word_q.score      <= score_w;
			out_word_q.flat_error <= flat_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_word  = out_word_q;

	// A new word only shows up right after the finish state.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q == cps_pkg::ST_FINISH))
		else $error("result appeared without a finished computation");

	// A flat curve always reports a zero score.
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_word.flat_error) |-> (out_word.score == '0))
		else $error("flat curve with nonzero score");

	// The stored sample count never exceeds the store depth.
	assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(MAX_SAMPLES))
		else $error("sample count beyond store depth");

	// The counting scan only reads entries that hold samples of this curve.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == cps_pkg::ST_COUNT && issue_q) |-> (CW'(ptr_q) < count_q))
		else $error("scan address beyond stored samples");

	// Handing over a result starts a fresh curve.
	assert property (@(posedge clk) disable iff (!arst_n)
		fin_fire |=> (count_q == '0 && sum_q == '0))
		else $error("curve statistics not cleared after result");

endmodule

`default_nettype wire

/* verif/tb.sv */
// Self-checking testbench for the curve peak score block with a built-in score predictor.
module tb;

	localparam int CLK_HALF = 6;
	localparam int RESET_CYCLES = 11;
	localparam int SETTLE_CYCLES = 200;
	localparam int WATCHDOG_LIMIT = 5000;
	localparam int STORE_DEPTH = cps_pkg::MAX_SAMPLES_DEF;

	typedef enum int {SHAPE_WIDE, SHAPE_NARROW, SHAPE_FLAT, SHAPE_EDGES} curve_shape_t;
	typedef enum logic [1:0] {READY_ALWAYS, READY_RANDOM, READY_SPARSE} ready_mode_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	cps_pkg::in_word_t in_word = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	cps_pkg::out_word_t out_word;
	logic cfg_write = 1'b0;
	logic [cps_pkg::CFG_IDX_W-1:0] cfg_index = cps_pkg::REG_REFERENCE_INDEX;
	logic [cps_pkg::REG_W-1:0] cfg_data = '0;

	// Predictor state: the curve being loaded and the window registers.
	longint held_samples [STORE_DEPTH];
	int held_count = 0;
	longint held_lo = 0;
	longint held_hi = 0;
	longint held_sum = 0;
	logic [cps_pkg::REG_W-1:0] win_end = '0;
	logic [cps_pkg::REG_W-1:0] win_back = '0;

	cps_pkg::in_word_t pending_words [$];
	cps_pkg::out_word_t expected_scores [$];
	int error_count = 0;
	int quiet_cycles = 0;
	int burst_left = 0;
	int gap_left = 0;
	ready_mode_t ready_mode = READY_ALWAYS;
	int mode_left = 0;
	logic [1:0] tick = '0;

	curve_peak_score dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_word(in_word),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_word(out_word),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #CLK_HALF clk = ~clk;

	// Magnitude of (m / d) * 2^16, rounded half away from zero, capped when huge.
	function automatic logic [63:0] q16_round_div(logic [63:0] m, logic [63:0] d);
		logic [63:0] whole;
		logic [63:0] rem;
		logic [63:0] q;
		int k;
		whole = m / d;
		rem = m % d;
		if (whole >= (64'd1 << 30))
			return 64'd1 << 40;
		q = whole;
		for (k = 0; k < 17; k++) begin
			rem = rem << 1;
			q = q << 1;
			if (rem >= d) begin
				rem = rem - d;
				q[0] = 1'b1;
			end
		end
		return (q + 64'd1) >> 1;
	endfunction

	function automatic cps_pkg::out_word_t curve_score();
		cps_pkg::out_word_t res;
		longint n;
		longint peak;
		longint span;
		longint inner;
		longint numer;
		logic [63:0] mag;
		logic [63:0] den;
		int stop_idx;
		int start_idx;
		int hits;
		int i;
		res = '0;
		n = held_count;
		if (held_count == 0 || held_hi == held_lo) begin
			res.flat_error = 1'b1;
			return res;
		end
		stop_idx = int'(win_end);
		if (stop_idx >= held_count)
			stop_idx = held_count - 1;
		start_idx = (int'(win_back) > stop_idx) ? 0 : stop_idx - int'(win_back);
		peak = held_samples[stop_idx];
		for (i = start_idx; i < stop_idx; i++)
			if (held_samples[i] > peak)
				peak = held_samples[i];
		hits = 0;
		for (i = 0; i < held_count; i++)
			if (held_samples[i] <= peak)
				hits++;
		span = held_sum - n * held_lo;
		inner = n * (peak - held_lo) - span;
		numer = longint'(hits) * inner;
		den = n * span;
		if (numer >= 0) begin
			mag = q16_round_div(numer, den);
			if (mag > 64'd8388607)
				mag = 64'd8388607;
		end else begin
			mag = q16_round_div(-numer, den);
			if (mag > 64'd8388608)
				mag = 64'd8388608;
			mag = -mag;
		end
		res.score = mag[cps_pkg::SCORE_W-1:0];
		return res;
	endfunction

	// Samples past a full store are dropped, but their last mark still closes the curve.
	function automatic void absorb_sample(cps_pkg::in_word_t w);
		longint x;
		x = longint'(w.sample);
		if (held_count < STORE_DEPTH) begin
			held_samples[held_count] = x;
			if (held_count == 0 || x < held_lo)
				held_lo = x;
			if (held_count == 0 || x > held_hi)
				held_hi = x;
			held_sum += x;
			held_count++;
		end
		if (w.is_last) begin
			expected_scores.push_back(curve_score());
			held_count = 0;
			held_lo = 0;
			held_hi = 0;
			held_sum = 0;
		end
	endfunction

	function automatic int next_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 30)
			return 0;
		if (r < 85)
			return $urandom_range(1, 4);
		if (r < 97)
			return $urandom_range(5, 20);
		return $urandom_range(30, 90);
	endfunction

	function automatic logic signed [cps_pkg::SAMPLE_W-1:0] draw_sample(curve_shape_t shape,
			logic signed [cps_pkg::SAMPLE_W-1:0] base);
		case (shape)
		SHAPE_NARROW: return base + 32'($urandom_range(0, 6)) - 32'sd3;
		SHAPE_FLAT: return base;
		SHAPE_EDGES: begin
			case ($urandom_range(0, 4))
			0: return 32'sh7FFFFFFF;
			1: return 32'sh80000000;
			2: return 32'sd0;
			3: return -32'sd1;
			default: return $urandom();
			endcase
		end
		default: return $urandom();
		endcase
	endfunction

	task automatic push_word(logic signed [cps_pkg::SAMPLE_W-1:0] value, logic last);
		cps_pkg::in_word_t w;
		w.sample = value;
		w.is_last = last;
		pending_words.push_back(w);
	endtask

	task automatic add_curve(int len, curve_shape_t shape);
		logic signed [cps_pkg::SAMPLE_W-1:0] base;
		int i;
		base = $urandom();
		for (i = 0; i < len; i++)
			push_word(draw_sample(shape, base), i == len - 1);
	endtask

	task automatic wait_drained();
		do
			@(negedge clk);
		while (pending_words.size() != 0 || in_valid || expected_scores.size() != 0);
	endtask

	// Registers change only once the block has gone quiet.
	task automatic next_phase(logic [cps_pkg::REG_W-1:0] end_v,
			logic [cps_pkg::REG_W-1:0] back_v);
		wait_drained();
		repeat (SETTLE_CYCLES) @(negedge clk);
		@(posedge clk);
		cfg_write <= 1'b1;
		cfg_index <= cps_pkg::REG_REFERENCE_INDEX;
		cfg_data <= end_v;
		@(posedge clk);
		cfg_index <= cps_pkg::REG_LOOKBACK_LENGTH;
		cfg_data <= back_v;
		@(posedge clk);
		cfg_write <= 1'b0;
		win_end = end_v;
		win_back = back_v;
		@(negedge clk);
	endtask

	initial begin
		int p;
		int queued;
		int len;
		int r;
		curve_shape_t shape;
		logic [cps_pkg::REG_W-1:0] end_v;
		logic [cps_pkg::REG_W-1:0] back_v;

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		// Reference beyond the curve, window clipped at zero, extreme values.
		next_phase(6'd63, 6'd63);
		push_word(32'sh7FFFFFFF, 1'b0);
		push_word(32'sh80000000, 1'b0);
		push_word(32'sh00010000, 1'b1);
		push_word(32'sh80000000, 1'b1);
		push_word(32'sh00012345, 1'b0);
		push_word(32'sh00012345, 1'b0);
		push_word(32'sh00012345, 1'b1);

		// Peak at the minimum gives a negative score; a lone maximum gives the largest one.
		next_phase(6'd0, 6'd0);
		push_word(-32'sd5, 1'b0);
		push_word(32'sd10, 1'b0);
		push_word(32'sd3, 1'b1);
		push_word(32'sd1000, 1'b0);
		repeat (4) push_word(32'sd0, 1'b0);
		push_word(32'sd0, 1'b1);

		// Window fully inside the curve.
		next_phase(6'd5, 6'd2);
		push_word(32'sd10, 1'b0);
		push_word(32'sd50, 1'b0);
		push_word(32'sd20, 1'b0);
		push_word(32'sd40, 1'b0);
		push_word(32'sd30, 1'b0);
		push_word(32'sd35, 1'b0);
		push_word(32'sd5, 1'b0);
		push_word(32'sd60, 1'b1);

		for (p = 0; p < 8; p++) begin
			end_v = $urandom_range(0, 20);
			back_v = $urandom_range(0, 63);
			case (p)
			0: begin end_v = 6'd0; back_v = 6'd63; end
			1: begin end_v = 6'd63; back_v = 6'd0; end
			2: begin end_v = 6'd63; back_v = 6'd63; end
			3: back_v = 6'd0;
			default: ;
			endcase
			next_phase(end_v, back_v);
			queued = 0;
			if (p == 0 || p == 5) begin
				// Overfilled store: the extra words must not move any statistic.
				add_curve(67, SHAPE_WIDE);
				queued = 67;
			end
			while (queued < 210) begin
				r = $urandom_range(0, 99);
				if (r < 80)
					len = $urandom_range(1, 16);
				else if (r < 95)
					len = $urandom_range(17, 48);
				else
					len = $urandom_range(55, 70);
				r = $urandom_range(0, 99);
				if (r < 40)
					shape = SHAPE_WIDE;
				else if (r < 75)
					shape = SHAPE_NARROW;
				else if (r < 85)
					shape = SHAPE_FLAT;
				else
					shape = SHAPE_EDGES;
				add_curve(len, shape);
				queued += len;
			end
		end

		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (error_count == 0)
			$display("** curve_peak_score: PASSED **");
		else
			$display("** curve_peak_score: FAILED **");
		$finish;
	end

	// Sender: bursts of words separated by random gaps.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_word <= '0;
			burst_left <= 0;
			gap_left <= 0;
		end else if (!in_valid || in_ready) begin
			if (gap_left > 0) begin
				in_valid <= 1'b0;
				gap_left <= gap_left - 1;
			end else if (pending_words.size() != 0) begin
				in_valid <= 1'b1;
				in_word <= pending_words.pop_front();
				if (burst_left > 1)
					burst_left <= burst_left - 1;
				else begin
					burst_left <= $urandom_range(1, 40);
					gap_left <= next_gap();
				end
			end else
				in_valid <= 1'b0;
		end
	end

	always @(posedge clk)
		if (arst_n && in_valid && in_ready)
			absorb_sample(in_word);

	// Receiver: checks each accepted word and switches between stall patterns.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			ready_mode <= READY_ALWAYS;
			mode_left <= 0;
			tick <= '0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_scores.size() == 0) begin
					$error("score: unexpected word, got %0d", out_word.score);
					error_count++;
				end else begin
					if (out_word.score !== expected_scores[0].score) begin
						$error("score: expected %0d, got %0d",
							expected_scores[0].score, out_word.score);
						error_count++;
					end
					if (out_word.flat_error !== expected_scores[0].flat_error) begin
						$error("flat_error: expected %0b, got %0b",
							expected_scores[0].flat_error, out_word.flat_error);
						error_count++;
					end
					void'(expected_scores.pop_front());
				end
			end
			if (mode_left == 0) begin
				ready_mode <= ready_mode_t'($urandom_range(0, 2));
				mode_left <= $urandom_range(50, 300);
			end else
				mode_left <= mode_left - 1;
			tick <= tick + 2'd1;
			case (ready_mode)
			READY_RANDOM: out_ready <= $urandom_range(0, 1);
			READY_SPARSE: out_ready <= (tick == 2'd0);
			default: out_ready <= 1'b1;
			endcase
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles <= 0;
		else if (quiet_cycles == WATCHDOG_LIMIT) begin
			$display("** curve_peak_score: FAILED **");
			$finish;
		end else
			quiet_cycles <= quiet_cycles + 1;
	end

endmodule
